// ===== hw/rtl/ntsp_pkg.sv =====
// Shared package for the number-to-spoken-phrase block.
// Holds widths, register codes, reset values, reciprocal constants and
// the structs passed between modules. Depends on nothing.
package ntsp_pkg;

  localparam int VAL_W     = 16;  // input number width
  localparam int ADDR_W    = 8;   // voice address width
  localparam int CFG_IDX_W = 2;   // configuration register index width
  localparam int DIG_W     = 4;   // one decimal digit
  localparam int REM_W     = 14;  // holds any clamped value up to 9999
  localparam int MAX_SEGS  = 7;   // longest phrase
  localparam int SEG_CNT_W = 3;   // counts 0 to MAX_SEGS
  localparam int N_STAGES  = 7;   // digit split pipeline depth
  localparam int N_CANDS   = 9;   // fixed candidate slots before packing

  localparam int MAX_SPOKEN_DEF = 9999;

  localparam int K1000 = 1000;
  localparam int K100  = 100;
  localparam int K10   = 10;

  // Reciprocal multipliers, exact over the ranges reached
  // (below 10000, below 1000 and below 100 in turn)
  localparam int DIV1000_MUL = 67109;
  localparam int DIV1000_SH  = 26;
  localparam int DIV100_MUL  = 656;
  localparam int DIV100_SH   = 16;
  localparam int DIV10_MUL   = 103;
  localparam int DIV10_SH    = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIGIT_BASE     = 2'd0,
    REG_TENS_WORD      = 2'd1,
    REG_HUNDREDS_WORD  = 2'd2,
    REG_THOUSANDS_WORD = 2'd3
  } cfg_reg_t;

  localparam logic [ADDR_W-1:0] DIGIT_BASE_RST     = 8'd5;
  localparam logic [ADDR_W-1:0] TENS_WORD_RST      = 8'd15;
  localparam logic [ADDR_W-1:0] HUNDREDS_WORD_RST  = 8'd16;
  localparam logic [ADDR_W-1:0] THOUSANDS_WORD_RST = 8'd17;

  typedef struct packed {
    logic [ADDR_W-1:0] digit_base;
    logic [ADDR_W-1:0] tens_word;
    logic [ADDR_W-1:0] hundreds_word;
    logic [ADDR_W-1:0] thousands_word;
  } cfg_t;

  typedef struct packed {
    logic             clamped;
    logic [DIG_W-1:0] q;
    logic [DIG_W-1:0] b;
    logic [DIG_W-1:0] s;
    logic [DIG_W-1:0] g;
  } digits_t;

endpackage

// ===== hw/rtl/ntsp_num_if.sv =====
// Input channel interface: valid/ready handshake carrying one number.
// Depends on ntsp_pkg.
interface ntsp_num_if;
  import ntsp_pkg::*;

  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] number_value;

  modport source (output valid, output number_value, input ready);
  modport sink   (input valid, input number_value, output ready);
endinterface

// ===== hw/rtl/ntsp_seg_if.sv =====
// Output channel interface: valid/ready handshake carrying one voice segment.
// Depends on ntsp_pkg.
interface ntsp_seg_if;
  import ntsp_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] voice_address;
  logic              last_segment;
  logic              was_clamped;

  modport source (output valid, output voice_address, output last_segment,
                  output was_clamped, input ready);
  modport sink   (input valid, input voice_address, input last_segment,
                  input was_clamped, output ready);
endinterface

// ===== hw/rtl/ntsp_digits.sv =====
// Clamp and decimal digit split, seven register stages with valid bits.
// Each constant division is a reciprocal multiply, the next stage subtracts.
// Depends on ntsp_pkg.
module ntsp_digits #(
  parameter int MAX_SPOKEN = ntsp_pkg::MAX_SPOKEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ntsp_pkg::VAL_W-1:0]   in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output ntsp_pkg::digits_t            out_digits
);
  import ntsp_pkg::*;

  typedef struct packed {
    logic             clamped;
    logic [REM_W-1:0] rem;
    logic [DIG_W-1:0] q;
    logic [DIG_W-1:0] b;
    logic [DIG_W-1:0] s;
  } work_t;

  work_t            st      [N_STAGES];
  work_t            st_next [N_STAGES];
  logic [N_STAGES-1:0] vld;
  logic [N_STAGES-1:0] adv;

  logic [30:0] p_q;
  logic [23:0] p_b;
  logic [16:0] p_s;
  logic        over;

  // Stage advances when empty or when the one after it advances
  always_comb begin
    adv[N_STAGES-1] = !vld[N_STAGES-1] || out_ready;
    for (int i = N_STAGES - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_ready = adv[0];

  assign over = in_value > VAL_W'(MAX_SPOKEN);
  assign p_q  = 31'(st[0].rem) * 31'(DIV1000_MUL);
  assign p_b  = 24'(st[2].rem) * 24'(DIV100_MUL);
  assign p_s  = 17'(st[4].rem) * 17'(DIV10_MUL);

  always_comb begin
    st_next[0]         = '0;
    st_next[0].clamped = over;
    st_next[0].rem     = over ? REM_W'(MAX_SPOKEN) : in_value[REM_W-1:0];

    st_next[1]     = st[0];
    st_next[1].q   = p_q[DIV1000_SH +: DIG_W];

    st_next[2]     = st[1];
    st_next[2].rem = st[1].rem - REM_W'(st[1].q) * REM_W'(K1000);

    st_next[3]     = st[2];
    st_next[3].b   = p_b[DIV100_SH +: DIG_W];

    st_next[4]     = st[3];
    st_next[4].rem = st[3].rem - REM_W'(st[3].b) * REM_W'(K100);

    st_next[5]     = st[4];
    st_next[5].s   = p_s[DIV10_SH +: DIG_W];

    st_next[6]     = st[5];
    st_next[6].rem = st[5].rem - REM_W'(st[5].s) * REM_W'(K10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int i = 1; i < N_STAGES; i++) begin
        if (adv[i]) vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N_STAGES; i++) begin
      if (adv[i]) st[i] <= st_next[i];
    end
  end

  assign out_valid          = vld[N_STAGES-1];
  assign out_digits.clamped = st[N_STAGES-1].clamped;
  assign out_digits.q       = st[N_STAGES-1].q;
  assign out_digits.b       = st[N_STAGES-1].b;
  assign out_digits.s       = st[N_STAGES-1].s;
  assign out_digits.g       = st[N_STAGES-1].rem[DIG_W-1:0];

endmodule

// ===== hw/rtl/ntsp_phrase.sv =====
// Phrase builder and segment serialiser with registered output.
// Packs the enabled words into a list, then shifts it out one per cycle while out_ready allows.
// Depends on ntsp_pkg.
module ntsp_phrase (
  input  logic                          clk,
  input  logic                          rst,
  input  ntsp_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ntsp_pkg::digits_t             in_digits,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ntsp_pkg::ADDR_W-1:0]   out_addr,
  output logic                          out_last,
  output logic                          out_clamped
);
  import ntsp_pkg::*;

  logic [ADDR_W-1:0]    cand [N_CANDS];
  logic [N_CANDS-1:0]   en;
  logic [ADDR_W-1:0]    list [MAX_SEGS];
  logic [SEG_CNT_W-1:0] count;

  logic [ADDR_W-1:0]    seg [MAX_SEGS];
  logic [SEG_CNT_W-1:0] left;
  logic                 clamped;

  logic emit;
  logic load;
  logic q_nz, b_nz, s_nz, g_nz;

  assign q_nz = in_digits.q != '0;
  assign b_nz = in_digits.b != '0;
  assign s_nz = in_digits.s != '0;
  assign g_nz = in_digits.g != '0;

  // Candidate words in speaking order
  always_comb begin
    cand[0] = cfg.digit_base + ADDR_W'(in_digits.q);
    cand[1] = cfg.thousands_word;
    cand[2] = cfg.digit_base + ADDR_W'(in_digits.b);
    cand[3] = cfg.hundreds_word;
    cand[4] = cfg.digit_base;
    cand[5] = cfg.digit_base + ADDR_W'(in_digits.s);
    cand[6] = cfg.tens_word;
    cand[7] = cfg.digit_base;
    cand[8] = cfg.digit_base + ADDR_W'(in_digits.g);

    en[0] = q_nz;
    en[1] = q_nz;
    en[2] = b_nz;
    en[3] = b_nz;
    en[4] = q_nz && !b_nz && (s_nz || g_nz);  // zero across a hundreds gap
    en[5] = s_nz;
    en[6] = s_nz;
    en[7] = !s_nz && g_nz && b_nz;            // zero across a tens gap
    en[8] = g_nz || !(q_nz || b_nz || s_nz);  // units, or the lone zero
  end

  // Pack enabled candidates to the front
  always_comb begin
    for (int i = 0; i < MAX_SEGS; i++) list[i] = '0;
    count = '0;
    for (int i = 0; i < N_CANDS; i++) begin
      if (en[i]) begin
        if (count < SEG_CNT_W'(MAX_SEGS)) list[count] = cand[i];
        count = count + 1'b1;
      end
    end
  end

  assign emit     = (left != '0) && (!out_valid || out_ready);
  assign in_ready = (left == '0) || (emit && left == SEG_CNT_W'(1));
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (load) begin
      left <= count;
    end else if (emit) begin
      left <= left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      seg     <= list;
      clamped <= in_digits.clamped;
    end else if (emit) begin
      for (int i = 0; i < MAX_SEGS - 1; i++) seg[i] <= seg[i+1];
      seg[MAX_SEGS-1] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_addr    <= seg[0];
      out_last    <= left == SEG_CNT_W'(1);
      out_clamped <= clamped;
    end
  end

endmodule

// ===== hw/rtl/number_to_spoken_phrase_core.sv =====
// Top level of the number-to-spoken-phrase block.
// Instantiates ntsp_digits and ntsp_phrase; depends on ntsp_pkg and the
// channel interfaces ntsp_num_if and ntsp_seg_if.
//
// Usage
//   num : one item is one unsigned 16-bit number, taken on valid and ready.
//         Numbers above MAX_SPOKEN are spoken as MAX_SPOKEN and flagged.
//   seg : one item is one voice address; last_segment marks the end of a
//         phrase and was_clamped repeats the clamp flag on every segment.
//   cfg : write port for digit_base, tens_word, hundreds_word and
//         thousands_word; write only while no phrase is in flight.
// Timing
//   The first segment of a number passes the seven digit split stages, the
//   load into the serialiser and the output register; later segments follow
//   one per cycle while seg.ready allows. A number gives 1 to 7 segments,
//   and the serialiser takes the next number only as the last segment of
//   the current one is emitted. The digit pipeline keeps taking numbers
//   while an earlier phrase is still being shifted out.
// Reset
//   Synchronous; empties every stage and restores the register defaults.
// Stalls
//   When seg.ready is low the output holds; the serialiser and then the
//   pipeline fill up and num.ready drops. Nothing is lost or repeated.
module number_to_spoken_phrase_core #(
  parameter int MAX_SPOKEN = ntsp_pkg::MAX_SPOKEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  ntsp_num_if.sink                         num,
  ntsp_seg_if.source                       seg,
  input  logic                             cfg_we,
  input  logic [ntsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ntsp_pkg::ADDR_W-1:0]      cfg_data
);
  import ntsp_pkg::*;

  cfg_t    cfg;
  digits_t digits;
  logic    digits_valid;
  logic    digits_ready;

  // Configuration registers; each index maps to one word address
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.digit_base     <= DIGIT_BASE_RST;
      cfg.tens_word      <= TENS_WORD_RST;
      cfg.hundreds_word  <= HUNDREDS_WORD_RST;
      cfg.thousands_word <= THOUSANDS_WORD_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DIGIT_BASE:     cfg.digit_base     <= cfg_data;
        REG_TENS_WORD:      cfg.tens_word      <= cfg_data;
        REG_HUNDREDS_WORD:  cfg.hundreds_word  <= cfg_data;
        REG_THOUSANDS_WORD: cfg.thousands_word <= cfg_data;
      endcase
    end
  end

  // Clamp and split into thousands, hundreds, tens and units
  ntsp_digits #(
    .MAX_SPOKEN (MAX_SPOKEN)
  ) u_digits (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (num.valid),
    .in_ready   (num.ready),
    .in_value   (num.number_value),
    .out_valid  (digits_valid),
    .out_ready  (digits_ready),
    .out_digits (digits)
  );

  // Pick the words of the phrase and shift them out one per cycle while seg.ready allows
  ntsp_phrase u_phrase (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (digits_valid),
    .in_ready    (digits_ready),
    .in_digits   (digits),
    .out_valid   (seg.valid),
    .out_ready   (seg.ready),
    .out_addr    (seg.voice_address),
    .out_last    (seg.last_segment),
    .out_clamped (seg.was_clamped)
  );

endmodule

// ===== dv/number_to_spoken_phrase_core_test.sv =====
// Self-checking testbench for number_to_spoken_phrase_core: drives numbers, predicts
// the voice segment sequence of each and compares every segment as it leaves.
// Depends on ntsp_pkg, ntsp_num_if, ntsp_seg_if and the core itself.
module number_to_spoken_phrase_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ntsp_pkg::*;

  localparam int SPOKEN_MAX = MAX_SPOKEN_DEF;
  // Tail wait after the queue empties, for any stray segment to show itself
  localparam int TAIL_CYCLES = 2 * (N_STAGES + 1);

  // One voice segment as seen on the output channel
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              last;
    logic              clamped;
  } segment_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_data;

  ntsp_num_if num_ch ();
  ntsp_seg_if seg_ch ();

  number_to_spoken_phrase_core #(
    .MAX_SPOKEN (SPOKEN_MAX)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .num       (num_ch),
    .seg       (seg_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register values the block currently holds, as far as the bench knows
  cfg_t        voice_cfg;
  // Segments still owed by the block, oldest first
  segment_t    spoken_q[$];
  int unsigned mismatches;
  // Chance (percent) of a gap before an item, and of a stall starting per cycle
  int unsigned gap_pct;
  int unsigned stall_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Guard against a hung handshake; the slowest legal run is far shorter
  initial begin
    #5_000_000;
    $display("[number_to_spoken_phrase_core] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Digit d plays at digit_base + d, wrapping within the address width
  function automatic logic [ADDR_W-1:0] digit_addr(input int unsigned d);
    return voice_cfg.digit_base + ADDR_W'(d);
  endfunction

  // Work out the segments that speak one number and queue them behind any
  // phrase still outstanding.
  function automatic void speak_number(input logic [VAL_W-1:0] raw);
    int unsigned v;
    int unsigned thou, hund, tens, units;
    logic        clamped;
    segment_t    phrase[$];
    v       = raw;
    clamped = (v > SPOKEN_MAX);
    if (clamped) begin
      v = SPOKEN_MAX;
    end
    thou  = v / 1000;
    hund  = (v / 100) % 10;
    tens  = (v / 10) % 10;
    units = v % 10;

    if (v >= 1000) begin
      phrase.push_back('{digit_addr(thou), 1'b0, clamped});
      phrase.push_back('{voice_cfg.thousands_word, 1'b0, clamped});
    end
    // A missing hundreds digit is spoken as one zero word, but only when
    // something nonzero still follows it
    if (v >= 100) begin
      if (hund != 0) begin
        phrase.push_back('{digit_addr(hund), 1'b0, clamped});
        phrase.push_back('{voice_cfg.hundreds_word, 1'b0, clamped});
      end else if ((tens | units) != 0) begin
        phrase.push_back('{digit_addr(0), 1'b0, clamped});
      end
    end
    // A tens gap gets its own zero word only after a spoken hundreds digit;
    // after a hundreds gap the zero word has already been said
    if (v >= 10) begin
      if (tens != 0) begin
        phrase.push_back('{digit_addr(tens), 1'b0, clamped});
        phrase.push_back('{voice_cfg.tens_word, 1'b0, clamped});
      end else if (units != 0 && hund != 0) begin
        phrase.push_back('{digit_addr(0), 1'b0, clamped});
      end
    end
    // Trailing zeros stay silent, except for the number zero itself
    if (v < 10 || units != 0) begin
      phrase.push_back('{digit_addr(units), 1'b0, clamped});
    end

    phrase[phrase.size() - 1].last = 1'b1;
    foreach (phrase[i]) begin
      spoken_q.push_back(phrase[i]);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Output side: ready with random stall bursts, and the segment check
  // --------------------------------------------------------------------------

  initial begin : seg_ready_drive
    int unsigned hold;
    hold         = 0;
    seg_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0 && $urandom_range(0, 99) < stall_pct) begin
        hold = $urandom_range(1, 11);
      end
      if (hold != 0) begin
        seg_ch.ready <= 1'b0;
        hold--;
      end else begin
        seg_ch.ready <= 1'b1;
      end
    end
  end

  // Compare every accepted segment with the oldest one owed
  always @(posedge clk) begin : segment_check
    segment_t got;
    segment_t want;
    if (!rst && seg_ch.valid && seg_ch.ready) begin
      got = '{seg_ch.voice_address, seg_ch.last_segment, seg_ch.was_clamped};
      if (spoken_q.size() == 0) begin
        $display("%0t: unexpected segment addr=%0d last=%0b clamped=%0b",
                 $time, got.addr, got.last, got.clamped);
        mismatches++;
      end else begin
        want = spoken_q.pop_front();
        if (got.addr !== want.addr || got.last !== want.last ||
            got.clamped !== want.clamped) begin
          $display("%0t: segment mismatch: expected addr=%0d last=%0b clamped=%0b,",
                   $time, want.addr, want.last, want.clamped,
                   " got addr=%0d last=%0b clamped=%0b",
                   got.addr, got.last, got.clamped);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offer one number and hold it until taken. Valid stays high afterwards so
  // that back-to-back items need no drop in between; a gap lowers it first.
  task automatic send_number(input logic [VAL_W-1:0] value);
    if ($urandom_range(0, 99) < gap_pct) begin
      num_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    num_ch.valid        <= 1'b1;
    num_ch.number_value <= value;
    do @(posedge clk); while (!num_ch.ready);
    speak_number(value);
  endtask

  // Drop valid and wait for every owed segment. Each number yields at least
  // one segment, so an empty queue means nothing is left in flight.
  task automatic await_silence();
    num_ch.valid <= 1'b0;
    while (spoken_q.size() != 0) @(posedge clk);
  endtask

  // Hold the write strobe across consecutive register writes
  task automatic put_reg(input cfg_reg_t idx, input logic [ADDR_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Write all four registers; call only with the block idle
  task automatic load_config(input cfg_t c);
    put_reg(REG_DIGIT_BASE, c.digit_base);
    put_reg(REG_TENS_WORD, c.tens_word);
    put_reg(REG_HUNDREDS_WORD, c.hundreds_word);
    put_reg(REG_THOUSANDS_WORD, c.thousands_word);
    cfg_we    <= 1'b0;
    voice_cfg  = c;
  endtask

  // Numbers built digit by digit with zeros favoured, so that the gap rules
  // are hit often; a share of full-width values exercises the clamp.
  function automatic logic [VAL_W-1:0] pick_number();
    int unsigned v;
    v = 0;
    case ($urandom_range(0, 9))
      0, 1: begin
        v = $urandom_range(0, (1 << VAL_W) - 1);
      end
      2: begin
        v = $urandom_range(0, 120);
      end
      default: begin
        for (int i = 0; i < 4; i++) begin
          v = v * 10 + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9));
        end
        // Trim to one to four digits
        v = v % (10 ** $urandom_range(1, 4));
      end
    endcase
    return VAL_W'(v);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset register values; zero, teens, every gap pattern, clamp and the
  // extremes of the input field
  task automatic test_corner_numbers();
    logic [VAL_W-1:0] corners[] = '{
      16'd0, 16'd1, 16'd9, 16'd10, 16'd11, 16'd19, 16'd20, 16'd99, 16'd100,
      16'd101, 16'd110, 16'd111, 16'd1000, 16'd1001, 16'd1010, 16'd1100,
      16'd2030, 16'd3405, 16'd7000, 16'd4567, 16'd9999, 16'd10000,
      16'd32768, 16'd65535, 16'd43690
    };
    gap_pct   = 20;
    stall_pct = 5;
    foreach (corners[i]) begin
      send_number(corners[i]);
    end
    await_silence();
  endtask

  // Register extremes, including a digit base that wraps past the top
  task automatic test_register_extremes();
    cfg_t settings[] = '{
      '{8'd0,   8'd0,   8'd0,   8'd0},
      '{8'd255, 8'd255, 8'd255, 8'd255},
      '{8'd250, 8'd0,   8'd128, 8'd255},
      '{8'd247, 8'd170, 8'd85,  8'd1}
    };
    logic [VAL_W-1:0] probes[] = '{
      16'd0, 16'd9, 16'd19, 16'd1005, 16'd1010, 16'd4321, 16'd9999, 16'd65535
    };
    gap_pct   = 30;
    stall_pct = 10;
    foreach (settings[s]) begin
      load_config(settings[s]);
      foreach (probes[p]) begin
        send_number(probes[p]);
      end
      await_silence();
    end
  endtask

  // Random numbers in phases, each with fresh register values and its own
  // amount of idling, which may be none at all
  task automatic test_random_numbers();
    int unsigned pcts[] = '{0, 30, 60};
    for (int phase = 0; phase < 5; phase++) begin
      load_config(cfg_t'($urandom));
      gap_pct   = pcts[$urandom_range(0, 2)];
      stall_pct = pcts[$urandom_range(0, 2)] / 4;
      repeat (35) send_number(pick_number());
      await_silence();
    end
  endtask

  // Full rate on both sides to close the run
  task automatic test_full_rate();
    load_config('{DIGIT_BASE_RST, TENS_WORD_RST, HUNDREDS_WORD_RST,
                  THOUSANDS_WORD_RST});
    gap_pct   = 0;
    stall_pct = 0;
    repeat (40) send_number(pick_number());
    await_silence();
  endtask

  initial begin : main_seq
    int unsigned guard;
    rst                 = 1'b1;
    num_ch.valid        = 1'b0;
    num_ch.number_value = '0;
    cfg_we              = 1'b0;
    cfg_index           = REG_DIGIT_BASE;
    cfg_data            = '0;
    voice_cfg           = '{DIGIT_BASE_RST, TENS_WORD_RST, HUNDREDS_WORD_RST,
                            THOUSANDS_WORD_RST};
    mismatches          = 0;
    gap_pct             = 0;
    stall_pct           = 0;
    guard               = 0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_corner_numbers();
    test_register_extremes();
    test_random_numbers();
    test_full_rate();

    // Let any stray segment show itself before judging
    while (spoken_q.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (spoken_q.size() != 0) begin
      $display("%0t: %0d segments never arrived", $time, spoken_q.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("[number_to_spoken_phrase_core] OK");
    end else begin
      $display("[number_to_spoken_phrase_core] ERROR");
    end
    $finish;
  end

endmodule
